// ----- rtl/core/qpht_pkg.sv -----
// ----------------------------------------------------------------------------
// qpht_pkg
// Shared types and constants for the quadratic-probe hash table core.
// ----------------------------------------------------------------------------
`default_nettype none

package qpht_pkg;

    // Field widths
    localparam int CMD_W  = 2;
    localparam int KEY_W  = 20;
    localparam int STAT_W = 2;
    localparam int SLOT_W = 10;
    localparam int CNT_W  = 10;

    // Default table size (prime)
    localparam int unsigned TABLE_SIZE_DEF = 1021;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_MISS = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL = 2'd2;

    // Input transfer
    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [KEY_W-1:0] key;
    } in_t;

    // Result transfer
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  probe_count;
    } out_t;

    // Control sequencer states
    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_HASH,
        S_READ,
        S_CHECK,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/core/qpht_key_mod.sv -----
// ----------------------------------------------------------------------------
// qpht_key_mod
// Three-stage pipeline computing key mod TABLE_SIZE by reciprocal
// multiplication followed by one compare-and-subtract correction.
// ----------------------------------------------------------------------------
`default_nettype none

module qpht_key_mod #(
    parameter int unsigned TABLE_SIZE = qpht_pkg::TABLE_SIZE_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    input  wire logic [qpht_pkg::KEY_W-1:0]    key,
    output logic                               out_valid,
    output logic [$clog2(TABLE_SIZE)-1:0]      rem
);

    localparam int KW    = qpht_pkg::KEY_W;
    localparam int SW    = $clog2(TABLE_SIZE);
    // floor(2^KW / N): quotient estimate is low by at most one
    localparam int unsigned RECIP = (32'd1 << KW) / TABLE_SIZE;

    logic                v1_reg, v2_reg, v3_reg;
    logic [KW-1:0]       key1_reg, key2_reg;
    logic [2*KW-1:0]     prod_reg;
    logic [KW-1:0]       qn_reg;
    logic [SW-1:0]       rem_reg;

    logic [KW-1:0]       q_est;
    logic [2*KW-1:0]     qn_full;
    logic [KW-1:0]       r_raw;
    logic [SW-1:0]       rem_next;

    // Quotient estimate and product back
    assign q_est   = prod_reg[2*KW-1:KW];
    assign qn_full = {{KW{1'b0}}, q_est} * (2*KW)'(TABLE_SIZE);

    // Remainder lies in [0, 2N); one correction
    always_comb begin
        r_raw = key2_reg - qn_reg;
        if (r_raw >= KW'(TABLE_SIZE)) begin
            rem_next = SW'(r_raw - KW'(TABLE_SIZE));
        end else begin
            rem_next = SW'(r_raw);
        end
    end

    // Valid pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Data pipeline
    always_ff @(posedge aclk) begin
        key1_reg <= key;
        prod_reg <= {{KW{1'b0}}, key} * (2*KW)'(RECIP);
        key2_reg <= key1_reg;
        qn_reg   <= qn_full[KW-1:0];
        rem_reg  <= rem_next;
    end

    assign out_valid = v3_reg;
    assign rem       = rem_reg;

endmodule

`default_nettype wire

// ----- rtl/core/quadratic_probe_hash_table_core.sv -----
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table_core
// Open-addressing hash table with quadratic probing over one slot memory.
//
//   channel  direction  payload        transfer when
//   s_       in         qpht_pkg::in_t  s_valid && s_ready
//   m_       out        qpht_pkg::out_t m_valid && m_ready
//
// Insert/search: accept, then key hashing, then for each probe a memory read
// followed by a check, then the result is loaded.
// Clear: a sweep that empties every slot of the memory, then the result.
// After reset the same sweep runs with s_ready low.
// The result register lets a new command be accepted while a result waits;
// a finished command holds in S_DONE while the result register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_probe_hash_table_core #(
    parameter int unsigned TABLE_SIZE = qpht_pkg::TABLE_SIZE_DEF
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire qpht_pkg::in_t   s_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output qpht_pkg::out_t       m_data
);

    localparam int KW = qpht_pkg::KEY_W;
    localparam int SW = $clog2(TABLE_SIZE);
    localparam int CW = $clog2(TABLE_SIZE + 1);

    // Slot memory: {used, key}
    logic [KW:0]        mem [TABLE_SIZE];
    logic [KW:0]        rd_data_reg;
    logic               mem_we;
    logic [SW-1:0]      mem_wa;
    logic [KW:0]        mem_wd;

    qpht_pkg::state_t   state_reg, state_next;
    logic [qpht_pkg::CMD_W-1:0] cmd_reg, cmd_next;
    logic [KW-1:0]      key_reg, key_next;
    logic [SW-1:0]      slot_reg, slot_next;
    logic [SW-1:0]      step_reg, step_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [SW-1:0]      sweep_reg, sweep_next;
    logic               pend_reg, pend_next;
    qpht_pkg::out_t     res_reg, res_next;
    logic               out_valid_reg, out_valid_next;
    qpht_pkg::out_t     out_reg, out_next;

    logic               hash_start;
    logic               hash_valid;
    logic [SW-1:0]      hash_rem;

    logic [SW:0]        slot_sum, step_sum;
    logic [SW-1:0]      slot_adv, step_adv;
    logic [CW-1:0]      probes;
    logic               slot_used;
    logic               key_match;
    logic               out_free;

    // Home slot hashing
    qpht_key_mod #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_key_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (hash_start),
        .key       (s_data.key),
        .out_valid (hash_valid),
        .rem       (hash_rem)
    );

    // Next probe: slot += 2(i+1), step += 2, both mod N
    always_comb begin
        slot_sum = {1'b0, slot_reg} + {1'b0, step_reg};
        step_sum = {1'b0, step_reg} + (SW+1)'(2);
        if (slot_sum >= (SW+1)'(TABLE_SIZE)) begin
            slot_adv = SW'(slot_sum - (SW+1)'(TABLE_SIZE));
        end else begin
            slot_adv = SW'(slot_sum);
        end
        if (step_sum >= (SW+1)'(TABLE_SIZE)) begin
            step_adv = SW'(step_sum - (SW+1)'(TABLE_SIZE));
        end else begin
            step_adv = SW'(step_sum);
        end
    end

    assign probes    = cnt_reg + CW'(1);
    assign slot_used = rd_data_reg[KW];
    assign key_match = (rd_data_reg[KW-1:0] == key_reg);
    assign out_free  = !out_valid_reg || m_ready;
    assign s_ready   = (state_reg == qpht_pkg::S_IDLE);
    assign hash_start = s_valid && s_ready &&
                        (s_data.command == qpht_pkg::CMD_INSERT ||
                         s_data.command == qpht_pkg::CMD_SEARCH);

    // Sequencer: next state, memory write and result
    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        slot_next      = slot_reg;
        step_next      = step_reg;
        cnt_next       = cnt_reg;
        sweep_next     = sweep_reg;
        pend_next      = pend_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        mem_we         = 1'b0;
        mem_wa         = slot_reg;
        mem_wd         = {1'b1, key_reg};

        case (state_reg)
            qpht_pkg::S_SWEEP: begin
                mem_we = 1'b1;
                mem_wa = sweep_reg;
                mem_wd = '0;
                sweep_next = sweep_reg + SW'(1);
                if (sweep_reg == SW'(TABLE_SIZE - 1)) begin
                    sweep_next = '0;
                    pend_next  = 1'b0;
                    state_next = pend_reg ? qpht_pkg::S_DONE : qpht_pkg::S_IDLE;
                end
            end
            qpht_pkg::S_IDLE: begin
                if (s_valid) begin
                    cmd_next = s_data.command;
                    key_next = s_data.key;
                    res_next = '{status: qpht_pkg::STATUS_OK, slot: '0,
                                 probe_count: '0};
                    case (s_data.command)
                        qpht_pkg::CMD_CLEAR: begin
                            sweep_next = '0;
                            pend_next  = 1'b1;
                            state_next = qpht_pkg::S_SWEEP;
                        end
                        qpht_pkg::CMD_INSERT, qpht_pkg::CMD_SEARCH: begin
                            state_next = qpht_pkg::S_HASH;
                        end
                        default: begin
                            state_next = qpht_pkg::S_DONE;
                        end
                    endcase
                end
            end
            qpht_pkg::S_HASH: begin
                if (hash_valid) begin
                    slot_next  = hash_rem;
                    step_next  = SW'(2);
                    cnt_next   = '0;
                    state_next = qpht_pkg::S_READ;
                end
            end
            qpht_pkg::S_READ: begin
                state_next = qpht_pkg::S_CHECK;
            end
            qpht_pkg::S_CHECK: begin
                state_next = qpht_pkg::S_DONE;
                if (!slot_used) begin
                    if (cmd_reg == qpht_pkg::CMD_INSERT) begin
                        mem_we   = 1'b1;
                        res_next = '{status: qpht_pkg::STATUS_OK,
                                     slot: qpht_pkg::SLOT_W'(slot_reg),
                                     probe_count: qpht_pkg::CNT_W'(probes)};
                    end else begin
                        res_next = '{status: qpht_pkg::STATUS_MISS, slot: '0,
                                     probe_count: qpht_pkg::CNT_W'(probes)};
                    end
                end else if (cmd_reg == qpht_pkg::CMD_SEARCH && key_match) begin
                    res_next = '{status: qpht_pkg::STATUS_OK,
                                 slot: qpht_pkg::SLOT_W'(slot_reg),
                                 probe_count: qpht_pkg::CNT_W'(probes)};
                end else if (probes == CW'(TABLE_SIZE)) begin
                    res_next = '{status: (cmd_reg == qpht_pkg::CMD_INSERT) ?
                                         qpht_pkg::STATUS_FULL : qpht_pkg::STATUS_MISS,
                                 slot: '0,
                                 probe_count: qpht_pkg::CNT_W'(probes)};
                end else begin
                    slot_next  = slot_adv;
                    step_next  = step_adv;
                    cnt_next   = probes;
                    state_next = qpht_pkg::S_READ;
                end
            end
            qpht_pkg::S_DONE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    state_next     = qpht_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = qpht_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= qpht_pkg::S_SWEEP;
            sweep_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cmd_reg  <= cmd_next;
        key_reg  <= key_next;
        slot_reg <= slot_next;
        step_reg <= step_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    // Slot memory write port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
    end

    // Slot memory read port, registered
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[slot_reg];
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // A failed insert has always walked the full probe sequence
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == qpht_pkg::STATUS_FULL |->
            m_data.probe_count == qpht_pkg::CNT_W'(TABLE_SIZE))
        else $error("insert failure with short probe count");

    // A miss never reports a slot
    a_miss_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == qpht_pkg::STATUS_MISS |-> m_data.slot == '0)
        else $error("search miss reports a slot");

    // Memory is written only by the sweep or an insert check
    a_write_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == qpht_pkg::S_SWEEP ||
                    (state_reg == qpht_pkg::S_CHECK &&
                     cmd_reg == qpht_pkg::CMD_INSERT)))
        else $error("slot memory written outside sweep or insert");

    // Probe counter stays below the table size while probing
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == qpht_pkg::S_READ || state_reg == qpht_pkg::S_CHECK) |->
            cnt_reg < CW'(TABLE_SIZE))
        else $error("probe counter out of range");

    // A pending result is not overwritten while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

endmodule

`default_nettype wire

// ----- tb/quadratic_probe_hash_table_core_tb.sv -----
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table_core_tb
// Self-checking bench for the quadratic-probe hash table core. A shadow copy
// of the slot table predicts status, slot and probe count for every accepted
// command. Each result transfer is checked in order against that prediction.
// Stimulus runs in three parts: a short directed set, random episodes that
// often crowd three probe chains, and a pass that saturates a single chain
// until an insert fails and a search walks the whole table.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_table_core_tb;

    import qpht_pkg::*;

    localparam int unsigned TBL          = TABLE_SIZE_DEF;
    localparam int unsigned KEY_MAX      = (1 << KEY_W) - 1;
    // Highest key row that still fits 20 bits for any base below TBL
    localparam int unsigned SPARE_ROW    = (KEY_MAX - (TBL - 1)) / TBL;
    localparam int unsigned RANDOM_ITEMS = 450;
    localparam int unsigned DRAIN_CYCLES = 64;
    localparam int unsigned CYCLE_LIMIT  = 12_000_000;
    // Command value three is not decoded; the core answers it as a no-op
    localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;

    // Shadow table and the queue of results still owed by the core
    class hash_shadow;
        logic [KEY_W-1:0] keys [TBL];
        bit               used [TBL];
        out_t             results_due [$];
        int unsigned      errors, results_checked;
        int unsigned      n_insert, n_search, n_clear, n_ignored;
        int unsigned      n_hit, n_miss, n_full, deepest;

        function new();
            foreach (used[j]) used[j] = 1'b0;
        endfunction

        // Slot visited by probe number step of a key
        function int unsigned chain_slot(logic [KEY_W-1:0] key, int unsigned step);
            longint unsigned k, i;
            k = key;
            i = step;
            return int'((k + i + i * i) % TBL);
        endfunction

        // Apply one command to the shadow table and return its outcome
        function out_t walk_chain(in_t cmd);
            out_t        r;
            int unsigned s;
            r = '0;
            case (cmd.command)
                CMD_CLEAR: begin
                    foreach (used[j]) used[j] = 1'b0;
                    n_clear++;
                end
                CMD_INSERT: begin
                    n_insert++;
                    r.status      = STATUS_FULL;
                    r.probe_count = CNT_W'(TBL);
                    for (int unsigned i = 0; i < TBL; i++) begin
                        s = chain_slot(cmd.key, i);
                        if (!used[s]) begin
                            used[s]       = 1'b1;
                            keys[s]       = cmd.key;
                            r.status      = STATUS_OK;
                            r.slot        = SLOT_W'(s);
                            r.probe_count = CNT_W'(i + 1);
                            break;
                        end
                    end
                    if (r.status == STATUS_FULL) n_full++;
                end
                CMD_SEARCH: begin
                    n_search++;
                    r.status      = STATUS_MISS;
                    r.probe_count = CNT_W'(TBL);
                    for (int unsigned i = 0; i < TBL; i++) begin
                        s = chain_slot(cmd.key, i);
                        if (!used[s]) begin
                            r.probe_count = CNT_W'(i + 1);
                            break;
                        end
                        if (keys[s] == cmd.key) begin
                            r.status      = STATUS_OK;
                            r.slot        = SLOT_W'(s);
                            r.probe_count = CNT_W'(i + 1);
                            break;
                        end
                    end
                    if (r.status == STATUS_OK) n_hit++;
                    else n_miss++;
                end
                default: begin
                    n_ignored++;
                end
            endcase
            if (int'(r.probe_count) > int'(deepest)) deepest = r.probe_count;
            return r;
        endfunction

        function void note_command(in_t cmd);
            results_due.push_back(walk_chain(cmd));
        endfunction

        task report(string what);
            errors++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_result(out_t got);
            out_t want;
            if (results_due.size() == 0) begin
                report($sformatf("result with nothing pending: status %0d slot %0d probes %0d",
                                 got.status, got.slot, got.probe_count));
                return;
            end
            want = results_due.pop_front();
            results_checked++;
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.slot !== want.slot)
                report($sformatf("slot %0d, want %0d", got.slot, want.slot));
            if (got.probe_count !== want.probe_count)
                report($sformatf("probe_count %0d, want %0d",
                                 got.probe_count, want.probe_count));
        endtask

        task close_out();
            if (results_due.size() != 0)
                report($sformatf("%0d results never arrived", results_due.size()));
            $display("Covered %0d inserts, %0d searches, %0d clears, %0d no-op commands",
                     n_insert, n_search, n_clear, n_ignored);
            $display("Checked %0d results: %0d hits, %0d misses, %0d full inserts, walk up to %0d",
                     results_checked, n_hit, n_miss, n_full, deepest);
        endtask
    endclass

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_t         s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_t        m_data;

    hash_shadow       sb = new();
    logic [KEY_W-1:0] live_keys [$];
    bit               steady = 1'b0;
    int unsigned      cycle_count = 0;

    quadratic_probe_hash_table_core u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Idle length: mostly none, some short, a few long; none in steady stretches
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (steady) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // Crowded keys share one probe chain: same value mod TBL
    function automatic logic [KEY_W-1:0] pick_key(bit crowd, int unsigned base);
        if (!crowd) return KEY_W'($urandom());
        return KEY_W'(base + TBL * $urandom_range(0, (KEY_MAX - base) / TBL));
    endfunction

    // One input transfer; called and returning at a falling edge
    task automatic push_cmd(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key);
        in_t         item;
        int unsigned gap;
        item.command = cmd;
        item.key     = key;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_command(item);
        if (cmd == CMD_CLEAR) live_keys.delete();
        else if (cmd == CMD_INSERT) live_keys.push_back(key);
        @(negedge aclk);
    endtask

    // Result side back-pressure
    initial begin : sink_pacing
        int unsigned hold;
        forever begin
            @(negedge aclk);
            hold = pick_gap();
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(negedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12) - 1) @(negedge aclk);
        end
    end

    // Check every result transfer
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    // Run guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results pending",
                     cycle_count, sb.results_due.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned      work_done, span, roll, fill_base;
        bit               crowd;
        int unsigned      bases [3];
        logic [KEY_W-1:0] spare_key;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: empty table, chain collisions, no-op, clear, key extremes
        push_cmd(CMD_SEARCH, '0);
        push_cmd(CMD_IGNORED, KEY_W'(KEY_MAX));
        push_cmd(CMD_INSERT, '0);
        push_cmd(CMD_INSERT, '0);
        push_cmd(CMD_INSERT, '0);
        push_cmd(CMD_SEARCH, '0);
        push_cmd(CMD_INSERT, KEY_W'(KEY_MAX));
        push_cmd(CMD_INSERT, KEY_W'(TBL));
        push_cmd(CMD_SEARCH, KEY_W'(TBL));
        push_cmd(CMD_SEARCH, KEY_W'(2 * TBL));
        push_cmd(CMD_SEARCH, KEY_W'(KEY_MAX));
        push_cmd(CMD_IGNORED, '0);
        push_cmd(CMD_SEARCH, '0);
        push_cmd(CMD_CLEAR, KEY_W'(KEY_MAX));
        push_cmd(CMD_SEARCH, '0);
        push_cmd(CMD_SEARCH, KEY_W'(KEY_MAX));
        push_cmd(CMD_INSERT, 20'h55555);
        push_cmd(CMD_INSERT, 20'hAAAAA);
        push_cmd(CMD_SEARCH, 20'hAAAAA);
        push_cmd(CMD_SEARCH, 20'h55555);
        push_cmd(CMD_CLEAR, '0);

        // Random episodes, each closed by a clear
        work_done = 0;
        while (work_done < RANDOM_ITEMS) begin
            steady = ($urandom_range(0, 4) == 0);
            span   = $urandom_range(20, 80);
            crowd  = ($urandom_range(0, 2) != 0);
            for (int b = 0; b < 3; b++) bases[b] = $urandom_range(0, TBL - 1);
            repeat (span) begin
                roll = $urandom_range(0, 99);
                if (roll < 3) begin
                    push_cmd(CMD_IGNORED, KEY_W'($urandom()));
                end else begin
                    work_done++;
                    if (roll < 5)
                        push_cmd(CMD_CLEAR, KEY_W'($urandom()));
                    else if (roll < 55)
                        push_cmd(CMD_INSERT, pick_key(crowd, bases[$urandom_range(0, 2)]));
                    else if (roll < 80 && live_keys.size() > 0)
                        push_cmd(CMD_SEARCH, live_keys[$urandom_range(0, live_keys.size() - 1)]);
                    else
                        push_cmd(CMD_SEARCH, pick_key(crowd, bases[$urandom_range(0, 2)]));
                end
            end
            push_cmd(CMD_CLEAR, KEY_W'($urandom()));
            work_done++;
        end

        // Saturate one chain: it holds (TBL+1)/2 distinct slots, so the next
        // insert fails and a search for an absent key walks all TBL probes
        steady    = 1'b0;
        fill_base = $urandom_range(0, TBL - 1);
        spare_key = KEY_W'(fill_base + SPARE_ROW * TBL);
        repeat ((TBL + 1) / 2 + 1)
            push_cmd(CMD_INSERT, KEY_W'(fill_base + TBL * $urandom_range(0, SPARE_ROW - 1)));
        push_cmd(CMD_SEARCH, spare_key);
        repeat (6) push_cmd(CMD_SEARCH, live_keys[$urandom_range(0, live_keys.size() - 1)]);
        push_cmd(CMD_INSERT, spare_key);
        push_cmd(CMD_INSERT, KEY_W'($urandom()));
        push_cmd(CMD_CLEAR, '0);
        push_cmd(CMD_SEARCH, spare_key);

        // Drain
        s_valid <= 1'b0;
        while (sb.results_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        sb.close_out();
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
